FILE: sv/stfl_pkg.sv
// Shared types and constants for the slot table with free list.
package stfl_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_UNALLOC = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

FILE: sv/stfl_ctrl.sv
// Controller state machine: request acceptance, execute step and result strobe.
module stfl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output stfl_pkg::cmd_t cmd
);
  import stfl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  assign busy = (state == ST_EXEC);

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not enter execute step");

  a_exec_then_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("execute step not followed by result strobe");

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

FILE: sv/stfl_dp.sv
// Datapath: word table, free stack, counters and result registers.
module stfl_dp #(
  parameter int CAPACITY  = stfl_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = stfl_pkg::WORD_BITS_DEF,
  localparam int SLOT_W   = $clog2(CAPACITY),
  localparam int COUNT_W  = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  stfl_pkg::cmd_t       cmd,
  input  logic [1:0]           op,
  input  logic [WORD_BITS-1:0] value,
  input  logic [SLOT_W-1:0]    index,
  output logic [SLOT_W-1:0]    slot,
  output logic [WORD_BITS-1:0] data,
  output logic [1:0]           status,
  output logic [COUNT_W-1:0]   live_count
);
  import stfl_pkg::*;

  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAPACITY);

  logic [WORD_BITS-1:0] table_mem [CAPACITY];
  logic [SLOT_W-1:0]    stack_mem [CAPACITY];

  logic [1:0]           op_q;
  logic [WORD_BITS-1:0] value_q;
  logic [SLOT_W-1:0]    index_q;
  logic [WORD_BITS-1:0] table_q;
  logic [SLOT_W-1:0]    stack_q;

  logic [COUNT_W-1:0]   free_depth;
  logic [COUNT_W-1:0]   high_water;
  logic [COUNT_W-1:0]   occupied;
  logic [COUNT_W-1:0]   free_depth_next;
  logic [COUNT_W-1:0]   high_water_next;
  logic [COUNT_W-1:0]   occupied_next;

  logic [SLOT_W-1:0]    slot_next;
  logic [WORD_BITS-1:0] data_next;
  status_t              status_next;

  logic                 table_we;
  logic [SLOT_W-1:0]    table_waddr;
  logic [WORD_BITS-1:0] table_wdata;
  logic                 stack_we;

  logic                 idx_unalloc;
  logic [SLOT_W-1:0]    stack_raddr;

  assign idx_unalloc = (COUNT_W'(index_q) >= high_water);
  assign stack_raddr = SLOT_W'(free_depth - COUNT_W'(1));

  always_comb begin
    free_depth_next = free_depth;
    high_water_next = high_water;
    occupied_next   = occupied;
    slot_next       = '0;
    data_next       = '0;
    status_next     = STATUS_OK;
    table_we        = 1'b0;
    table_waddr     = index_q;
    table_wdata     = '0;
    stack_we        = 1'b0;
    case (op_q)
      OP_ADD: begin
        if (free_depth != '0) begin
          free_depth_next = free_depth - COUNT_W'(1);
          slot_next       = stack_q;
          table_we        = 1'b1;
        end else if (high_water >= CAP) begin
          status_next = STATUS_FULL;
        end else begin
          high_water_next = high_water + COUNT_W'(1);
          slot_next       = SLOT_W'(high_water);
          table_we        = 1'b1;
        end
        table_waddr = slot_next;
        table_wdata = value_q;
        if (table_we && occupied < CAP) begin
          occupied_next = occupied + COUNT_W'(1);
        end
      end
      OP_REMOVE: begin
        slot_next = index_q;
        if (idx_unalloc) begin
          status_next = STATUS_UNALLOC;
        end else begin
          if (occupied != '0) begin
            occupied_next = occupied - COUNT_W'(1);
          end
          if (free_depth < CAP) begin
            stack_we        = 1'b1;
            free_depth_next = free_depth + COUNT_W'(1);
          end
          table_we = 1'b1;
        end
      end
      OP_READ: begin
        slot_next = index_q;
        if (idx_unalloc) begin
          status_next = STATUS_UNALLOC;
        end else begin
          data_next = table_q;
        end
      end
      default: begin
        slot_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && table_we) begin
      table_mem[table_waddr] <= table_wdata;
    end
    if (cmd.load) begin
      table_q <= table_mem[index];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && stack_we) begin
      stack_mem[SLOT_W'(free_depth)] <= index_q;
    end
    if (cmd.load) begin
      stack_q <= stack_mem[stack_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op;
      value_q <= value;
      index_q <= index;
    end
    if (cmd.exec) begin
      slot       <= slot_next;
      data       <= data_next;
      status     <= status_next;
      live_count <= occupied_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_depth <= '0;
      high_water <= '0;
      occupied   <= '0;
    end else if (cmd.exec) begin
      free_depth <= free_depth_next;
      high_water <= high_water_next;
      occupied   <= occupied_next;
    end
  end

  a_full_only_when_exhausted: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && status_next == STATUS_FULL) |-> (high_water == CAP && free_depth == '0))
    else $error("full reported while slots remain");

  a_remove_keeps_high_water: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op_q == OP_REMOVE) |=> $stable(high_water))
    else $error("high-water mark moved on remove");

  a_counters_bounded: assert property (@(posedge clk) disable iff (rst)
    (high_water <= CAP) && (free_depth <= CAP) && (occupied <= CAP))
    else $error("counter beyond capacity");

endmodule

FILE: sv/slot_table_with_free_list.sv
// Top level of the slot table with LIFO free list.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low;
//   op, value and index are sampled at that edge. op selects add, remove or
//   read; an unused op code returns slot 0, data 0, status ok.
//   Each request gives exactly one result: done is high for one cycle with
//   slot, data, status and live_count valid in that cycle.
//   Timing: the accepting edge moves the controller into its execute step; the
//   edge that ends that step loads the result registers and raises done. No new
//   request is taken while busy, since the free stack top and the table word
//   are read into registers at acceptance and must land before the write step.
//   busy is high for the cycle after acceptance; start may be held high.
//   The receiver cannot stall; a result not taken in its strobe cycle is lost.
//   Reset (rst, synchronous) empties the table: high-water mark, free stack
//   depth and the occupied count go to zero. No clearing pass is run; table words and
//   stack entries are written before they can be read.
module slot_table_with_free_list #(
  parameter int CAPACITY  = stfl_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = stfl_pkg::WORD_BITS_DEF,
  localparam int SLOT_W   = $clog2(CAPACITY),
  localparam int COUNT_W  = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           op,
  input  logic [WORD_BITS-1:0] value,
  input  logic [SLOT_W-1:0]    index,
  output logic                 done,
  output logic [SLOT_W-1:0]    slot,
  output logic [WORD_BITS-1:0] data,
  output logic [1:0]           status,
  output logic [COUNT_W-1:0]   live_count
);
  import stfl_pkg::*;

  cmd_t cmd;

  stfl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  stfl_dp #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (op),
    .value      (value),
    .index      (index),
    .slot       (slot),
    .data       (data),
    .status     (status),
    .live_count (live_count)
  );

endmodule

FILE: tb/tb_slot_table_with_free_list.sv
`timescale 1ns / 100ps
// Self-checking bench for the slot table: directed table, random phases, predicted results.
module tb_slot_table_with_free_list;
  import stfl_pkg::*;

  localparam int SLOTS = CAPACITY_DEF;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int COUNT_W = $clog2(SLOTS + 1);
  localparam int STALL_LIMIT = 1000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [31:0] data;
    status_t status;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  typedef struct packed {
    logic [1:0] op;
    logic [31:0] value;
    logic [SLOT_W-1:0] index;
    logic pinned;
    outcome_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] op = '0;
  logic [31:0] value = '0;
  logic [SLOT_W-1:0] index = '0;
  logic busy;
  logic done;
  logic [SLOT_W-1:0] slot;
  logic [31:0] data;
  logic [1:0] status;
  logic [COUNT_W-1:0] live_count;

  bit [31:0] word_store [SLOTS];
  bit [SLOT_W-1:0] freed_slots [SLOTS];
  int unsigned freed_depth = 0;
  int unsigned issued_slots = 0;
  int unsigned live_slots = 0;

  outcome_t pending [$];
  outcome_t expected_now;
  outcome_t no_pin = '0;
  script_row_t script [$];
  int errors = 0;
  int sent = 0;
  int results = 0;
  int full_hits = 0;
  int unalloc_hits = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  slot_table_with_free_list uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .value(value),
    .index(index),
    .done(done),
    .slot(slot),
    .data(data),
    .status(status),
    .live_count(live_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic outcome_t next_outcome(input logic [1:0] o, input logic [31:0] v,
                                            input logic [SLOT_W-1:0] i);
    outcome_t r;
    r.slot = i;
    r.data = '0;
    r.status = STATUS_OK;
    case (o)
      OP_ADD: begin
        if (freed_depth == 0 && issued_slots >= SLOTS) begin
          r.slot = '0;
          r.status = STATUS_FULL;
          full_hits++;
        end else begin
          if (freed_depth > 0) begin
            freed_depth--;
            r.slot = freed_slots[SLOT_W'(freed_depth)];
          end else begin
            r.slot = SLOT_W'(issued_slots);
            issued_slots++;
          end
          word_store[r.slot] = v;
          if (live_slots < SLOTS) live_slots++;
        end
      end
      OP_REMOVE, OP_READ: begin
        if (i >= issued_slots) begin
          r.status = STATUS_UNALLOC;
          unalloc_hits++;
        end else if (o == OP_READ) begin
          r.data = word_store[i];
        end else begin
          if (live_slots > 0) live_slots--;
          if (freed_depth < SLOTS) begin
            freed_slots[SLOT_W'(freed_depth)] = i;
            freed_depth++;
          end
          word_store[i] = '0;
        end
      end
      default: r.slot = '0;
    endcase
    r.count = COUNT_W'(live_slots);
    return r;
  endfunction

  function automatic void script_row(input logic [1:0] o, input logic [31:0] v,
                                     input logic [SLOT_W-1:0] i, input logic pin,
                                     input logic [SLOT_W-1:0] s, input logic [31:0] d,
                                     input status_t st, input logic [COUNT_W-1:0] c);
    script_row_t r;
    r.op = o;
    r.value = v;
    r.index = i;
    r.pinned = pin;
    r.want.slot = s;
    r.want.data = d;
    r.want.status = st;
    r.want.count = c;
    script.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    errors++;
  endtask

  task automatic issue(input logic [1:0] o, input logic [31:0] v,
                       input logic [SLOT_W-1:0] i, input logic pin, input outcome_t typed);
    int gap;
    outcome_t want;
    if (sent % 64 == 0) steady = ($urandom_range(0, 3) == 0);
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    value <= v;
    index <= i;
    do @(posedge clk); while (busy);
    want = next_outcome(o, v, i);
    if (pin) want = typed;
    pending.push_back(want);
    sent++;
  endtask

  task automatic random_request(input int add_pct, input int remove_pct, input int read_pct);
    int pick;
    logic [1:0] o;
    logic [SLOT_W-1:0] i;
    pick = $urandom_range(0, 99);
    if (issued_slots > 0 && $urandom_range(0, 7) != 0)
      i = SLOT_W'($urandom_range(0, issued_slots - 1));
    else
      i = SLOT_W'($urandom);
    if (pick < add_pct) o = OP_ADD;
    else if (pick < add_pct + remove_pct) o = OP_REMOVE;
    else if (pick < add_pct + remove_pct + read_pct) o = OP_READ;
    else o = OP_UNUSED;
    issue(o, $urandom, i, 1'b0, no_pin);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        results++;
        if (pending.size() == 0) begin
          report_mismatch("unrequested result, slot", '0, 32'(slot));
        end else begin
          expected_now = pending.pop_front();
          if (slot !== expected_now.slot)
            report_mismatch("slot", 32'(expected_now.slot), 32'(slot));
          if (data !== expected_now.data)
            report_mismatch("data", expected_now.data, data);
          if (status !== expected_now.status)
            report_mismatch("status", 32'(expected_now.status), 32'(status));
          if (live_count !== expected_now.count)
            report_mismatch("live_count", 32'(expected_now.count), 32'(live_count));
        end
      end
      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("no request or result for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // after reset: errors, unused op, extremes, then reuse order of freed slots
    script_row(OP_READ, '0, '0, 1'b1, '0, '0, STATUS_UNALLOC, '0);
    script_row(OP_REMOVE, '0, '1, 1'b1, '1, '0, STATUS_UNALLOC, '0);
    script_row(OP_UNUSED, '1, '1, 1'b1, '0, '0, STATUS_OK, '0);
    script_row(OP_ADD, '1, '1, 1'b1, '0, '0, STATUS_OK, COUNT_W'(1));
    script_row(OP_ADD, '0, '0, 1'b1, SLOT_W'(1), '0, STATUS_OK, COUNT_W'(2));
    script_row(OP_READ, '0, SLOT_W'(0), 1'b1, SLOT_W'(0), '1, STATUS_OK, COUNT_W'(2));
    script_row(OP_READ, '1, SLOT_W'(1), 1'b1, SLOT_W'(1), '0, STATUS_OK, COUNT_W'(2));
    script_row(OP_READ, '0, SLOT_W'(2), 1'b1, SLOT_W'(2), '0, STATUS_UNALLOC, COUNT_W'(2));
    script_row(OP_REMOVE, '0, SLOT_W'(0), 1'b0, '0, '0, STATUS_OK, '0);
    script_row(OP_READ, '0, SLOT_W'(0), 1'b0, '0, '0, STATUS_OK, '0);
    script_row(OP_ADD, 32'hA5A5_A5A5, '0, 1'b0, '0, '0, STATUS_OK, '0);
    script_row(OP_REMOVE, '0, SLOT_W'(1), 1'b0, '0, '0, STATUS_OK, '0);
    script_row(OP_REMOVE, '0, SLOT_W'(1), 1'b0, '0, '0, STATUS_OK, '0);
    script_row(OP_REMOVE, '0, SLOT_W'(0), 1'b0, '0, '0, STATUS_OK, '0);
    script_row(OP_ADD, 32'h1234_5678, '0, 1'b0, '0, '0, STATUS_OK, '0);
    script_row(OP_ADD, 32'h5A5A_5A5A, '0, 1'b0, '0, '0, STATUS_OK, '0);
    script_row(OP_ADD, 32'h8765_4321, '0, 1'b0, '0, '0, STATUS_OK, '0);
    script_row(OP_ADD, '0, '1, 1'b0, '0, '0, STATUS_OK, '0);
    script_row(OP_READ, '0, SLOT_W'(1), 1'b0, '0, '0, STATUS_OK, '0);
    script_row(OP_READ, '0, SLOT_W'(0), 1'b0, '0, '0, STATUS_OK, '0);
    script_row(OP_REMOVE, '0, SLOT_W'(2), 1'b0, '0, '0, STATUS_OK, '0);
    script_row(OP_UNUSED, '0, '0, 1'b0, '0, '0, STATUS_OK, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k])
      issue(script[k].op, script[k].value, script[k].index, script[k].pinned, script[k].want);

    // stack up repeated removes on the free stack, pop it all back, then add six more
    repeat (150)
      issue(OP_REMOVE, $urandom, SLOT_W'($urandom_range(0, issued_slots - 1)), 1'b0, no_pin);
    while (freed_depth > 0) issue(OP_ADD, $urandom, SLOT_W'($urandom), 1'b0, no_pin);
    repeat (6) issue(OP_ADD, $urandom, SLOT_W'($urandom), 1'b0, no_pin);
    drain();

    repeat (370) random_request(45, 25, 25);

    repeat (200) random_request(20, 35, 40);
    drain();
    repeat (4) @(posedge clk);

    $display("%0d requests, %0d results checked, %0d mismatches", sent, results, errors);
    $display("high-water mark %0d, %0d full adds, %0d unallocated accesses",
             issued_slots, full_hits, unalloc_hits);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/stfl_pkg.sv
sv/stfl_ctrl.sv
sv/stfl_dp.sv
sv/slot_table_with_free_list.sv
tb/tb_slot_table_with_free_list.sv
